@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL files; only the top-level detector includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define MSD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("msd assertion failed");

// Check on every clock edge, reset included.
`define MSD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("msd assertion failed");

`endif

@@ rtl/core/msd_pkg.sv @@
`default_nettype none

package msd_pkg;

  localparam int WINDOW_DEPTH = 5;

  localparam int SPEED_W   = 20;
  localparam int COURSE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int LAT_W     = 31;
  localparam int LON_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam int SUM_W  = SPEED_W + $clog2(WINDOW_DEPTH);
  localparam int MEAN_K = SUM_W + $clog2(WINDOW_DEPTH);
  localparam longint unsigned MEAN_RECIP_INT =
    ((64'd1 << MEAN_K) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam logic [MEAN_K-1:0] MEAN_RECIP = MEAN_K'(MEAN_RECIP_INT);

  localparam logic [SPEED_W-1:0] LIMIT_RESET = 20'd1000;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_STOPPED = 2'd1,
    MODE_ACCEL   = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_LIMIT  = 2'd0,
    REG_START_LIMIT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic all_still;
    logic pair_below;
    logic prev_no_course;
  } win_stat_t;

  typedef struct packed {
    logic [TIME_W-1:0] tag;
    logic [LAT_W-1:0]  lat;
    logic [LON_W-1:0]  lon;
  } fix_pos_t;

endpackage

`default_nettype wire

@@ rtl/core/motion_start_stop_detector.sv @@
// An accepted word is registered in stage one, then in the output stage.
// Throughput: one word per cycle; the window cells and the running sum update
// at acceptance, the mean (reciprocal multiply) is formed in the output stage.
// A stall on the output holds both stages; the input stays open while stage one is free.
// Reset: synchronous; clears the window, modes, fix records, limits to 1000.
`default_nettype none

module motion_start_stop_detector
  import msd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPEED_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SPEED_W-1:0]   speed,
  input  logic [COURSE_W-1:0]  course,
  input  logic [TIME_W-1:0]    time_tag,
  input  logic [LAT_W-1:0]     latitude,
  input  logic [LON_W-1:0]     longitude,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SPEED_W-1:0]   mean_speed,
  output logic [1:0]           vehicle_state,
  output logic [1:0]           measure_state,
  output logic                 clear_distance,
  output logic                 start_found,
  output logic [TIME_W-1:0]    start_time,
  output logic [LAT_W-1:0]     start_latitude,
  output logic [LON_W-1:0]     start_longitude
);

  `include "assert_macros.svh"

  logic [SPEED_W-1:0] stop_limit;
  logic [SPEED_W-1:0] start_limit;

  logic      adv;
  logic      in_fire;
  win_stat_t stat;
  logic [SUM_W-1:0] sum_next;

  mode_t    veh_mode;
  mode_t    meas_mode;
  fix_pos_t prev_fix;
  fix_pos_t start_rec;
  fix_pos_t cur_fix;

  mode_t    veh_chk;
  mode_t    meas_chk;
  mode_t    veh_next;
  mode_t    meas_next;
  logic     clear_now;
  logic     found_now;
  fix_pos_t start_next;

  logic             a_valid;
  logic [SUM_W-1:0] a_sum;
  mode_t            a_veh;
  mode_t            a_meas;
  logic             a_clear;
  logic             a_found;
  fix_pos_t         a_start;

  logic [SUM_W+MEAN_K-1:0] mean_prod;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_limit  <= LIMIT_RESET;
      start_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STOP_LIMIT:  stop_limit  <= cfg_data;
        REG_START_LIMIT: start_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = !rst && (!a_valid || adv);
  assign in_fire  = in_valid && in_ready;

  msd_window u_window (
    .clk         (clk),
    .rst         (rst),
    .shift       (in_fire),
    .speed_in    (speed),
    .course_in   (course),
    .stop_limit  (stop_limit),
    .start_limit (start_limit),
    .sum_next    (sum_next),
    .stat        (stat)
  );

  assign cur_fix = '{tag: time_tag, lat: latitude, lon: longitude};

  always_comb begin
    veh_chk    = stat.all_still ? MODE_STOPPED : veh_mode;
    clear_now  = (veh_chk == MODE_STOPPED);
    meas_chk   = clear_now ? MODE_STOPPED : meas_mode;
    found_now  = (course != '0) && stat.prev_no_course && stat.pair_below;
    veh_next   = found_now ? MODE_ACCEL : veh_chk;
    meas_next  = found_now ? MODE_ACCEL : meas_chk;
    start_next = found_now ? prev_fix : start_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      veh_mode  <= MODE_UNKNOWN;
      meas_mode <= MODE_UNKNOWN;
      prev_fix  <= '0;
      start_rec <= '0;
    end else if (in_fire) begin
      veh_mode  <= veh_next;
      meas_mode <= meas_next;
      prev_fix  <= cur_fix;
      start_rec <= start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_sum   <= sum_next;
      a_veh   <= veh_next;
      a_meas  <= meas_next;
      a_clear <= clear_now;
      a_found <= found_now;
      a_start <= start_next;
    end
  end

  assign mean_prod = {{MEAN_K{1'b0}}, a_sum} * {{SUM_W{1'b0}}, MEAN_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      mean_speed      <= mean_prod[MEAN_K +: SPEED_W];
      vehicle_state   <= a_veh;
      measure_state   <= a_meas;
      clear_distance  <= a_clear;
      start_found     <= a_found;
      start_time      <= a_start.tag;
      start_latitude  <= a_start.lat;
      start_longitude <= a_start.lon;
    end
  end

  `MSD_ASSERT(found_sets_accel, (in_fire && found_now) |=> (veh_mode == MODE_ACCEL && meas_mode == MODE_ACCEL))
  `MSD_ASSERT(clear_means_stopped, (a_valid && a_clear) |-> (a_meas == MODE_STOPPED || a_found))
  `MSD_ASSERT(stage_holds, (a_valid && !adv) |=> (a_valid && $stable(a_sum) && $stable(a_start)))
  `MSD_ASSERT_ALWAYS(reset_empties, rst |=> (!a_valid && !out_valid))

endmodule

`default_nettype wire

@@ rtl/core/msd_cell.sv @@
`default_nettype none

module msd_cell
  import msd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  logic [SPEED_W-1:0] speed_in,
  input  logic               no_course_in,
  input  logic [SPEED_W-1:0] stop_limit,
  output logic [SPEED_W-1:0] speed,
  output logic               no_course,
  output logic               still
);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed     <= '0;
      no_course <= 1'b1;
    end else if (shift) begin
      speed     <= speed_in;
      no_course <= no_course_in;
    end
  end

  assign still = no_course && (speed < stop_limit);

endmodule

`default_nettype wire

@@ rtl/core/msd_window.sv @@
`default_nettype none

module msd_window
  import msd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [SPEED_W-1:0]  speed_in,
  input  logic [COURSE_W-1:0] course_in,
  input  logic [SPEED_W-1:0]  stop_limit,
  input  logic [SPEED_W-1:0]  start_limit,
  output logic [SUM_W-1:0]    sum_next,
  output win_stat_t           stat
);

  logic [SPEED_W-1:0]      cell_speed [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] cell_nc;
  logic [WINDOW_DEPTH-1:0] cell_still;
  logic [SUM_W-1:0]        running_sum;
  logic                    new_nc;
  logic                    new_still;
  logic [SPEED_W:0]        pair_sum;

  assign new_nc    = (course_in == '0);
  assign new_still = new_nc && (speed_in < stop_limit);

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic [SPEED_W-1:0] speed_feed;
    logic               nc_feed;

    if (i == WINDOW_DEPTH - 1) begin : g_head
      assign speed_feed = speed_in;
      assign nc_feed    = new_nc;
    end else begin : g_body
      assign speed_feed = cell_speed[i+1];
      assign nc_feed    = cell_nc[i+1];
    end

    msd_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .shift        (shift),
      .speed_in     (speed_feed),
      .no_course_in (nc_feed),
      .stop_limit   (stop_limit),
      .speed        (cell_speed[i]),
      .no_course    (cell_nc[i]),
      .still        (cell_still[i])
    );
  end

  assign sum_next = running_sum + SUM_W'(speed_in) - SUM_W'(cell_speed[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (shift) begin
      running_sum <= sum_next;
    end
  end

  assign pair_sum = {1'b0, cell_speed[WINDOW_DEPTH-1]} + {1'b0, cell_speed[WINDOW_DEPTH-2]};

  assign stat.all_still      = new_still && (&cell_still[WINDOW_DEPTH-1:1]);
  assign stat.pair_below     = pair_sum[SPEED_W:1] < start_limit;
  assign stat.prev_no_course = cell_nc[WINDOW_DEPTH-1];

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench
  import msd_pkg::*;
();

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_FIXES = 325;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  typedef struct packed {
    logic [SPEED_W-1:0]  speed;
    logic [COURSE_W-1:0] course;
    fix_pos_t            pos;
  } fix_t;

  typedef struct packed {
    logic [SPEED_W-1:0] mean;
    logic [1:0]         veh;
    logic [1:0]         meas;
    logic               clr;
    logic               found;
    fix_pos_t           start;
  } motion_rpt_t;

  typedef struct packed {
    fix_t        fix;
    logic        typed;
    motion_rpt_t rpt;
  } fix_row_t;

  localparam fix_row_t FIX_ROWS [15] = '{
    '{'{20'd5, 16'd1, '{32'd100, 31'sd7, 32'sd9}}, 1'b1,
      '{20'd1, MODE_ACCEL, MODE_ACCEL, 1'b0, 1'b1, '{32'd0, 31'd0, 32'd0}}},
    '{'{20'd0, 16'd0, '{32'hFFFF_FFFF, 31'sd900000000, 32'sd1800000000}}, 1'b1,
      '{20'd1, MODE_ACCEL, MODE_ACCEL, 1'b0, 1'b0, '{32'd0, 31'd0, 32'd0}}},
    '{'{20'd1, 16'd2, '{32'd3, 31'sd0, 32'sd0}}, 1'b1,
      '{20'd1, MODE_ACCEL, MODE_ACCEL, 1'b0, 1'b1,
        '{32'hFFFF_FFFF, 31'sd900000000, 32'sd1800000000}}},
    '{'{20'd0, 16'd0, '{32'd4, -31'sd900000000, -32'sd1800000000}}, 1'b0, '0},
    '{'{20'd0, 16'h8000, '{32'd5, 31'sd1, -32'sd1}}, 1'b0, '0},
    '{'{20'd0, 16'd0, '{32'd6, 31'sd2, 32'sd2}}, 1'b0, '0},
    '{'{20'd999, 16'd0, '{32'd7, 31'sd3, 32'sd3}}, 1'b0, '0},
    '{'{20'd0, 16'd0, '{32'd8, 31'sd4, 32'sd4}}, 1'b0, '0},
    '{'{20'd500, 16'd0, '{32'd9, 31'sd5, 32'sd5}}, 1'b0, '0},
    '{'{20'd999, 16'd0, '{32'd10, 31'sd6, 32'sd6}}, 1'b0, '0},
    '{'{20'd1000, 16'd0, '{32'd11, -31'sd12345, 32'sd54321}}, 1'b0, '0},
    '{'{20'hFFFFF, 16'hFFFF, '{32'd12, 31'sd8, 32'sd8}}, 1'b0, '0},
    '{'{20'hFFFFF, 16'd0, '{32'd0, 31'sd9, 32'sd9}}, 1'b0, '0},
    '{'{20'd0, 16'd1, '{32'd14, 31'sd10, 32'sd10}}, 1'b0, '0},
    '{'{20'h55555, 16'h5555, '{32'h5555_5555, 31'sd11, 32'sd11}}, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SPEED_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SPEED_W-1:0]  speed = '0;
  logic [COURSE_W-1:0] course = '0;
  logic [TIME_W-1:0]   time_tag = '0;
  logic [LAT_W-1:0]    latitude = '0;
  logic [LON_W-1:0]    longitude = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SPEED_W-1:0]  mean_speed;
  logic [1:0]          vehicle_state;
  logic [1:0]          measure_state;
  logic                clear_distance;
  logic                start_found;
  logic [TIME_W-1:0]   start_time;
  logic [LAT_W-1:0]    start_latitude;
  logic [LON_W-1:0]    start_longitude;

  logic               gaps_on = 1'b1;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  motion_rpt_t        due_reports [$];
  motion_rpt_t        head_rpt;

  logic [SPEED_W-1:0] spd_hist [WINDOW_DEPTH];
  logic               crs_none [WINDOW_DEPTH];
  fix_pos_t           last_pos;
  fix_pos_t           start_pos;
  logic [1:0]         veh_mode;
  logic [1:0]         meas_mode;
  logic [SPEED_W-1:0] stop_lim;
  logic [SPEED_W-1:0] start_lim;

  motion_start_stop_detector i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .speed           (speed),
    .course          (course),
    .time_tag        (time_tag),
    .latitude        (latitude),
    .longitude       (longitude),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .mean_speed      (mean_speed),
    .vehicle_state   (vehicle_state),
    .measure_state   (measure_state),
    .clear_distance  (clear_distance),
    .start_found     (start_found),
    .start_time      (start_time),
    .start_latitude  (start_latitude),
    .start_longitude (start_longitude)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void reset_tracker();
    int i;
    for (i = 0; i < WINDOW_DEPTH; i++) begin
      spd_hist[i] = '0;
      crs_none[i] = 1'b1;
    end
    last_pos  = '0;
    start_pos = '0;
    veh_mode  = MODE_UNKNOWN;
    meas_mode = MODE_UNKNOWN;
    stop_lim  = LIMIT_RESET;
    start_lim = LIMIT_RESET;
  endfunction

  function automatic motion_rpt_t track_fix(input fix_t f);
    motion_rpt_t r;
    int unsigned total;
    int unsigned pair;
    logic        still;
    logic        moving;
    int          i;
    moving = (f.course != '0);
    for (i = 0; i < WINDOW_DEPTH - 1; i++) begin
      spd_hist[i] = spd_hist[i+1];
      crs_none[i] = crs_none[i+1];
    end
    spd_hist[WINDOW_DEPTH-1] = f.speed;
    crs_none[WINDOW_DEPTH-1] = !moving;
    total = 0;
    still = 1'b1;
    for (i = 0; i < WINDOW_DEPTH; i++) begin
      total += spd_hist[i];
      if (!crs_none[i] || spd_hist[i] >= stop_lim) still = 1'b0;
    end
    r = '0;
    r.mean = SPEED_W'(total / WINDOW_DEPTH);
    if (still) veh_mode = MODE_STOPPED;
    if (veh_mode == MODE_STOPPED) begin
      meas_mode = MODE_STOPPED;
      r.clr = 1'b1;
    end
    pair = spd_hist[WINDOW_DEPTH-2];
    pair = (pair + spd_hist[WINDOW_DEPTH-3]) / 2;
    if (moving && crs_none[WINDOW_DEPTH-2] && pair < start_lim) begin
      start_pos = last_pos;
      veh_mode  = MODE_ACCEL;
      meas_mode = MODE_ACCEL;
      r.found   = 1'b1;
    end
    last_pos = f.pos;
    r.veh   = veh_mode;
    r.meas  = meas_mode;
    r.start = start_pos;
    return r;
  endfunction

  function automatic logic [SPEED_W-1:0] below(input logic [SPEED_W-1:0] lim);
    int unsigned top;
    top = lim;
    return (lim == '0) ? '0 : SPEED_W'($urandom_range(top - 1, 0));
  endfunction

  function automatic logic [SPEED_W-1:0] near(input logic [SPEED_W-1:0] lim);
    int unsigned lo;
    int unsigned hi;
    lo = (lim > 2) ? lim - 2 : 0;
    hi = (lim > SPEED_MAX - 2) ? SPEED_MAX : lim + 2;
    return SPEED_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [SPEED_W-1:0] pick_speed();
    unique case ($urandom_range(3))
      0: return SPEED_W'($urandom);
      1: return below(stop_lim);
      2: return $urandom_range(1) ? near(stop_lim) : near(start_lim);
      default: return SPEED_W'($urandom_range(2000, 0));
    endcase
  endfunction

  function automatic fix_t random_fix();
    fix_t   f;
    int     lat;
    longint lon;
    lat = int'($urandom_range(1800000000, 0)) - 900000000;
    lon = longint'($urandom_range(32'd3600000000, 0)) - 64'sd1800000000;
    f.speed   = pick_speed();
    f.course  = COURSE_W'($urandom);
    f.pos.tag = $urandom;
    f.pos.lat = LAT_W'(lat);
    f.pos.lon = LON_W'(lon);
    return f;
  endfunction

  task automatic check_field(input string fld, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s: expected %0h, got %0h", fld, want, got);
    end
  endtask

  task automatic send_fix(input fix_t f, input logic typed, input motion_rpt_t typed_rpt);
    motion_rpt_t r;
    while (gaps_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    speed     <= f.speed;
    course    <= f.course;
    time_tag  <= f.pos.tag;
    latitude  <= f.pos.lat;
    longitude <= f.pos.lon;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = track_fix(f);
    due_reports.push_back(typed ? typed_rpt : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (idx)
      REG_STOP_LIMIT:  stop_lim = val;
      REG_START_LIMIT: start_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [SPEED_W-1:0] stop_val,
                            input logic [SPEED_W-1:0] start_val, input logic poke_spare);
    write_reg(REG_STOP_LIMIT, stop_val);
    write_reg(REG_START_LIMIT, start_val);
    if (poke_spare) begin
      write_reg(REG_SPARE_LO, SPEED_W'($urandom));
      write_reg(REG_SPARE_HI, SPEED_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input int count);
    int   sent;
    int   pick;
    fix_t f;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // standstill run, then a fix that tries to start
        repeat ($urandom_range(9, 3)) begin
          f = random_fix();
          f.course = '0;
          f.speed = $urandom_range(1) ? below(stop_lim)
                  : below((start_lim < stop_lim) ? start_lim : stop_lim);
          send_fix(f, 1'b0, '0);
          sent++;
        end
        f = random_fix();
        f.course = COURSE_W'($urandom_range(65535, 1));
        send_fix(f, 1'b0, '0);
        sent++;
      end else if (pick < 80) begin
        repeat ($urandom_range(8, 1)) begin
          f = random_fix();
          f.course = COURSE_W'($urandom_range(65535, 1));
          send_fix(f, 1'b0, '0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(5, 1)) begin
          f = random_fix();
          if ($urandom_range(9) < 3) f.course = '0;
          send_fix(f, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(99) >= 10);
    if (!rst && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("result word with no fix pending");
      end else begin
        head_rpt = due_reports.pop_front();
        check_field("mean_speed", head_rpt.mean, mean_speed);
        check_field("vehicle_state", head_rpt.veh, vehicle_state);
        check_field("measure_state", head_rpt.meas, measure_state);
        check_field("clear_distance", head_rpt.clr, clear_distance);
        check_field("start_found", head_rpt.found, start_found);
        check_field("start_time", head_rpt.start.tag, start_time);
        check_field("start_latitude", head_rpt.start.lat, start_latitude);
        check_field("start_longitude", head_rpt.start.lon, start_longitude);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    reset_tracker();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (FIX_ROWS[k]) send_fix(FIX_ROWS[k].fix, FIX_ROWS[k].typed, FIX_ROWS[k].rpt);
    run_traffic(PHASE_FIXES);
    drain();

    set_limits('0, '0, 1'b0);
    run_traffic(PHASE_FIXES);
    drain();

    gaps_on <= 1'b0;
    set_limits(SPEED_MAX, SPEED_MAX, 1'b0);
    run_traffic(PHASE_FIXES);
    drain();

    gaps_on <= 1'b1;
    set_limits(20'd5000, 20'd200, 1'b1);
    run_traffic(PHASE_FIXES);
    drain();

    set_limits(SPEED_W'($urandom), SPEED_W'($urandom_range(20000, 0)), 1'b0);
    run_traffic(PHASE_FIXES);
    drain();

    set_limits(20'd300, 20'd60000, 1'b0);
    run_traffic(PHASE_FIXES);
    drain();

    if (mismatches == 0 && due_reports.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/msd_pkg.sv
rtl/core/msd_cell.sv
rtl/core/msd_window.sv
rtl/core/motion_start_stop_detector.sv
tb/testbench.sv
